[rtl/aes128_pkg.sv]
// Package: AES-128 types, tables and round functions.
package aes128_pkg;

  localparam int NumRounds = 10;
  localparam int NumWords  = 44;
  localparam int RoundW    = 4;

  localparam logic [0:0] CMD_DECRYPT = 1'b0;
  localparam logic [0:0] CMD_ENCRYPT = 1'b1;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_EXPAND
  } ks_state_t;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   valid;
    logic   enc;
    block_t data;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte n of a block sits at bits [127-8n -: 8].
  function automatic logic [7:0] get_byte(input block_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s, input logic inverse);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse)
          t[127 - 8*((((c + r) & 3) * 4) + r) -: 8] = INV_SBOX[get_byte(s, c*4 + r)];
        else
          t[127 - 8*((((c + 4 - r) & 3) * 4) + r) -: 8] = SBOX[get_byte(s, c*4 + r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_fwd(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4 + 1);
      a2 = get_byte(s, c*4 + 2);
      a3 = get_byte(s, c*4 + 3);
      t[127 - 8*(c*4)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[127 - 8*(c*4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  // Inverse mix: premultiply by {04}x^2+{05} then forward mix.
  function automatic block_t mix_inv(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, u, v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4 + 1);
      a2 = get_byte(s, c*4 + 2);
      a3 = get_byte(s, c*4 + 3);
      u  = xtime(xtime(a0 ^ a2));
      v  = xtime(xtime(a1 ^ a3));
      t[127 - 8*(c*4)     -: 8] = a0 ^ u;
      t[127 - 8*(c*4 + 1) -: 8] = a1 ^ v;
      t[127 - 8*(c*4 + 2) -: 8] = a2 ^ u;
      t[127 - 8*(c*4 + 3) -: 8] = a3 ^ v;
    end
    return mix_fwd(t);
  endfunction

endpackage

[rtl/aes128_key_expand.sv]
// Key expansion: one round key (four words) per cycle into a round-key file.
module aes128_key_expand #(
  parameter int NUM_ROUNDS = aes128_pkg::NumRounds
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic [127:0] key,
  output logic         busy,
  output logic [127:0] key_sched [NUM_ROUNDS+1]
);

  localparam int CntW = $clog2(NUM_ROUNDS + 1);

  aes128_pkg::ks_state_t state, state_next;
  logic [CntW-1:0] count;
  logic [7:0]      rcon;
  logic [127:0]    prev;
  logic [127:0]    nxt;
  logic [31:0]     t;
  logic [31:0]     w0, w1, w2, w3;

  assign prev = key_sched[count];

  always_comb begin
    t  = {aes128_pkg::SBOX[prev[23:16]], aes128_pkg::SBOX[prev[15:8]],
          aes128_pkg::SBOX[prev[7:0]], aes128_pkg::SBOX[prev[31:24]]} ^ {rcon, 24'h0};
    w0 = prev[127:96] ^ t;
    w1 = prev[95:64] ^ w0;
    w2 = prev[63:32] ^ w1;
    w3 = prev[31:0] ^ w2;
    nxt = {w0, w1, w2, w3};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aes128_pkg::KS_IDLE:   if (load) state_next = aes128_pkg::KS_EXPAND;
      aes128_pkg::KS_EXPAND: if (load) state_next = aes128_pkg::KS_EXPAND;
                             else if (count == CntW'(NUM_ROUNDS - 1))
                               state_next = aes128_pkg::KS_IDLE;
      default:               state_next = aes128_pkg::KS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state == aes128_pkg::KS_EXPAND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes128_pkg::KS_IDLE;
      count <= '0;
      rcon  <= 8'h01;
    end else begin
      state <= state_next;
      if (load) begin
        count <= '0;
        rcon  <= 8'h01;
      end else if (busy) begin
        count <= count + 1'b1;
        rcon  <= aes128_pkg::xtime(rcon);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) key_sched[0] <= key;
    else if (busy) key_sched[count + 1'b1] <= nxt;
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> count < CntW'(NUM_ROUNDS))
    else $error("key expansion count overran");
  assert property (@(posedge clk) disable iff (rst) load |=> busy)
    else $error("key load did not start expansion");
  assert property (@(posedge clk) disable iff (rst)
      (busy && !load && count == CntW'(NUM_ROUNDS - 1)) |=> !busy)
    else $error("key expansion did not finish");

endmodule

[rtl/aes128_round.sv]
// One registered cipher round; a stage of the round pipeline.
module aes128_round (
  input  logic               clk,
  input  logic               rst,
  input  aes128_pkg::stage_t in_stage,
  input  logic [127:0]       key_enc,
  input  logic [127:0]       key_dec,
  input  logic               first,
  input  logic               last,
  output aes128_pkg::stage_t out_stage
);

  aes128_pkg::block_t enc_data, dec_data, x;

  always_comb begin
    x = aes128_pkg::sub_shift(in_stage.data, 1'b0);
    enc_data = (last ? x : aes128_pkg::mix_fwd(x)) ^ key_enc;
    dec_data = aes128_pkg::sub_shift(
                 first ? in_stage.data : aes128_pkg::mix_inv(in_stage.data), 1'b1) ^ key_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) out_stage.valid <= 1'b0;
    else     out_stage.valid <= in_stage.valid;
    out_stage.enc  <= in_stage.enc;
    out_stage.data <= in_stage.enc ? enc_data : dec_data;
  end

endmodule

[rtl/aes128_block_cipher_unit.sv]
// Top level: AES-128 ECB encrypt/decrypt with ten-stage round pipeline.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  input     | start & !busy             | command, block_high, block_low
//  result    | strobe (one cycle)        | result_high, result_low
//  config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// A block transfers at an edge into one entry register for the initial key add,
// then passes one register per round stage; strobe is the valid bit of the last
// round register and the result transfers with it. A new block may enter every
// cycle while busy is low. A pending key write holds busy high; after the write
// busy stays high while the key is loaded into the expander and then while round
// keys 1 to 10 are built. cfg_ready drops while the expander runs or any block is
// in flight. Reset clears all valid bits and the expansion sequencer. The receiver
// cannot stall results.
module aes128_block_cipher_unit #(
  parameter int NUM_ROUNDS = aes128_pkg::NumRounds
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        strobe,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]  key_high, key_low;
  logic         key_load;
  logic         ks_busy;
  logic [127:0] key_sched [NUM_ROUNDS+1];
  aes128_pkg::stage_t stages [NUM_ROUNDS+1];
  logic         cfg_fire;
  logic         in_flight;

  // Any valid stage still reads the round keys.
  always_comb begin
    in_flight = 1'b0;
    for (int k = 0; k <= NUM_ROUNDS; k++) in_flight = in_flight || stages[k].valid;
  end

  // Key writes land in the cycle before expansion restarts from the new key.
  assign cfg_ready = !ks_busy && !in_flight;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      key_load <= 1'b0;
    end else begin
      key_load <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_index)
          aes128_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
          aes128_pkg::CFG_KEY_LOW:  key_low  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aes128_key_expand #(.NUM_ROUNDS(NUM_ROUNDS)) u_keys (
    .clk       (clk),
    .rst       (rst),
    .load      (key_load),
    .key       ({key_high, key_low}),
    .busy      (ks_busy),
    .key_sched (key_sched)
  );

  // Hold blocks off while a key write waits, so a key never changes under one.
  assign busy = ks_busy || key_load || cfg_valid;

  // Entry stage: add the first key of the chosen direction.
  always_ff @(posedge clk) begin
    if (rst) stages[0].valid <= 1'b0;
    else     stages[0].valid <= start && !busy;
    stages[0].enc  <= command;
    stages[0].data <= {block_high, block_low} ^
                      ((command == aes128_pkg::CMD_ENCRYPT) ? key_sched[0]
                                                            : key_sched[NUM_ROUNDS]);
  end

  // Decrypt stage k uses key NUM_ROUNDS-k (k from 1); last stage adds key 0.
  for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_round
    aes128_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_stage  (stages[k-1]),
      .key_enc   (key_sched[k]),
      .key_dec   (key_sched[NUM_ROUNDS-k]),
      .first     ((k == 1) ? 1'b1 : 1'b0),
      .last      ((k == NUM_ROUNDS) ? 1'b1 : 1'b0),
      .out_stage (stages[k])
    );
  end

  assign strobe      = stages[NUM_ROUNDS].valid;
  assign result_high = stages[NUM_ROUNDS].data[127:64];
  assign result_low  = stages[NUM_ROUNDS].data[63:0];

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> stages[0].valid)
    else $error("accepted block did not enter the pipeline");
  assert property (@(posedge clk) disable iff (rst) cfg_fire |=> busy)
    else $error("key write did not raise busy");
  assert property (@(posedge clk) disable iff (rst) stages[0].valid |-> !$past(busy))
    else $error("block entered during key expansion");
  assert property (@(posedge clk) disable iff (rst) cfg_fire |-> !in_flight)
    else $error("key written with a block in flight");

endmodule
